/* design/lrk_pkg.sv */
// Shared types, constants and the microcode table of the Lorenz RK4 integrator.
// No dependencies; lrk_ctrl, lrk_dp and lorenz_rk4_step_core import this package.
`default_nettype none

package lrk_pkg;

  // Fixed-point defaults and the register fraction width.
  localparam int FracBitsDef   = 24;
  localparam int StateWidthDef = 32;
  localparam int RegFrac       = 24;

  // Register reset values.
  localparam logic [23:0] StepRst  = 24'd7457;
  localparam logic [30:0] SigmaRst = 31'd167772160;
  localparam logic [30:0] RhoRst   = 31'd469762048;
  localparam logic [30:0] BetaRst  = 31'd55924053;
  localparam logic [31:0] StartRst = 32'd16777216;

  // Configuration register indexes.
  localparam logic [2:0] CfgStep   = 3'd0;
  localparam logic [2:0] CfgSigma  = 3'd1;
  localparam logic [2:0] CfgRho    = 3'd2;
  localparam logic [2:0] CfgBeta   = 3'd3;
  localparam logic [2:0] CfgStartX = 3'd4;
  localparam logic [2:0] CfgStartY = 3'd5;
  localparam logic [2:0] CfgStartZ = 3'd6;

  // Operand addresses: the lower three quarters address the register file, the top quarter
  // selects aligned configuration values and the constant one.
  localparam logic [4:0] A_PX  = 5'd0;
  localparam logic [4:0] A_PY  = 5'd1;
  localparam logic [4:0] A_PZ  = 5'd2;
  localparam logic [4:0] A_QX  = 5'd3;
  localparam logic [4:0] A_QY  = 5'd4;
  localparam logic [4:0] A_QZ  = 5'd5;
  localparam logic [4:0] A_KX  = 5'd6;
  localparam logic [4:0] A_KY  = 5'd7;
  localparam logic [4:0] A_KZ  = 5'd8;
  localparam logic [4:0] A_SX  = 5'd9;
  localparam logic [4:0] A_SY  = 5'd10;
  localparam logic [4:0] A_SZ  = 5'd11;
  localparam logic [4:0] A_BX  = 5'd12;
  localparam logic [4:0] A_BY  = 5'd13;
  localparam logic [4:0] A_BZ  = 5'd14;
  localparam logic [4:0] A_T0  = 5'd15;
  localparam logic [4:0] A_T1  = 5'd16;
  localparam logic [4:0] A_ONE = 5'd24;
  localparam logic [4:0] A_H   = 5'd25;
  localparam logic [4:0] A_SG  = 5'd26;
  localparam logic [4:0] A_RG  = 5'd27;
  localparam logic [4:0] A_BG  = 5'd28;
  localparam logic [4:0] A_STX = 5'd29;
  localparam logic [4:0] A_STY = 5'd30;
  localparam logic [4:0] A_STZ = 5'd31;

  // Microprogram entry points.
  localparam logic [6:0] PcInit    = 7'd0;
  localparam logic [6:0] PcRestart = 7'd4;
  localparam logic [6:0] PcStep    = 7'd8;
  localparam logic [6:0] PcD1      = 7'd8;
  localparam logic [6:0] PcD2      = 7'd29;
  localparam logic [6:0] PcD3      = 7'd53;
  localparam logic [6:0] PcD4      = 7'd71;

  typedef enum logic [2:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_ASR,
    OP_MUL,
    OP_DIV6,
    OP_CLAMP,
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } uop_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       first;
    logic       clear_sat;
    logic       push;
    op_e        op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } lrk_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;
    logic out_free;
  } lrk_sts_t;

  function automatic uop_t lrk_uop(op_e op, logic [4:0] dst, logic [4:0] a, logic [4:0] b);
    uop_t u;
    u.op    = op;
    u.dst   = dst;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  // One Lorenz derivative evaluation of point (x, y, z) into K.
  function automatic uop_t lrk_deriv(logic [3:0] off, logic [4:0] x, logic [4:0] y,
                                     logic [4:0] z);
    uop_t u;
    case (off)
      4'd0:    u = lrk_uop(OP_SUB, A_T0, y, x);
      4'd1:    u = lrk_uop(OP_MUL, A_KX, A_SG, A_T0);
      4'd2:    u = lrk_uop(OP_MUL, A_T0, A_RG, x);
      4'd3:    u = lrk_uop(OP_SUB, A_T0, A_T0, y);
      4'd4:    u = lrk_uop(OP_MUL, A_T1, x, z);
      4'd5:    u = lrk_uop(OP_SUB, A_KY, A_T0, A_T1);
      4'd6:    u = lrk_uop(OP_MUL, A_T0, x, y);
      4'd7:    u = lrk_uop(OP_MUL, A_T1, A_BG, z);
      4'd8:    u = lrk_uop(OP_SUB, A_KZ, A_T0, A_T1);
      default: u = lrk_uop(OP_END, A_T0, A_T0, A_T0);
    endcase
    return u;
  endfunction

  // The microprogram: reset load, restart load and one RK4 step.
  function automatic uop_t lrk_ucode(logic [6:0] pc);
    uop_t u;
    logic [6:0] rel;
    rel = 7'd0;
    case (pc) inside
      7'd0:  u = lrk_uop(OP_CLAMP, A_PX, A_ONE, A_ONE);
      7'd1:  u = lrk_uop(OP_CLAMP, A_PY, A_ONE, A_ONE);
      7'd2:  u = lrk_uop(OP_CLAMP, A_PZ, A_ONE, A_ONE);
      7'd4:  u = lrk_uop(OP_CLAMP, A_PX, A_STX, A_STX);
      7'd5:  u = lrk_uop(OP_CLAMP, A_PY, A_STY, A_STY);
      7'd6:  u = lrk_uop(OP_CLAMP, A_PZ, A_STZ, A_STZ);
      [7'd8:7'd16]: begin
        rel = pc - PcD1;
        u = lrk_deriv(rel[3:0], A_PX, A_PY, A_PZ);
      end
      7'd17: u = lrk_uop(OP_MOV, A_SX, A_KX, A_KX);
      7'd18: u = lrk_uop(OP_MOV, A_SY, A_KY, A_KY);
      7'd19: u = lrk_uop(OP_MOV, A_SZ, A_KZ, A_KZ);
      7'd20: u = lrk_uop(OP_MUL, A_T0, A_H, A_KX);
      7'd21: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd22: u = lrk_uop(OP_ADD, A_QX, A_PX, A_T0);
      7'd23: u = lrk_uop(OP_MUL, A_T0, A_H, A_KY);
      7'd24: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd25: u = lrk_uop(OP_ADD, A_QY, A_PY, A_T0);
      7'd26: u = lrk_uop(OP_MUL, A_T0, A_H, A_KZ);
      7'd27: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd28: u = lrk_uop(OP_ADD, A_QZ, A_PZ, A_T0);
      [7'd29:7'd37]: begin
        rel = pc - PcD2;
        u = lrk_deriv(rel[3:0], A_QX, A_QY, A_QZ);
      end
      7'd38: u = lrk_uop(OP_ADD, A_T0, A_KX, A_KX);
      7'd39: u = lrk_uop(OP_ADD, A_SX, A_SX, A_T0);
      7'd40: u = lrk_uop(OP_ADD, A_T0, A_KY, A_KY);
      7'd41: u = lrk_uop(OP_ADD, A_SY, A_SY, A_T0);
      7'd42: u = lrk_uop(OP_ADD, A_T0, A_KZ, A_KZ);
      7'd43: u = lrk_uop(OP_ADD, A_SZ, A_SZ, A_T0);
      7'd44: u = lrk_uop(OP_MUL, A_T0, A_H, A_KX);
      7'd45: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd46: u = lrk_uop(OP_ADD, A_QX, A_PX, A_T0);
      7'd47: u = lrk_uop(OP_MUL, A_T0, A_H, A_KY);
      7'd48: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd49: u = lrk_uop(OP_ADD, A_QY, A_PY, A_T0);
      7'd50: u = lrk_uop(OP_MUL, A_T0, A_H, A_KZ);
      7'd51: u = lrk_uop(OP_ASR, A_T0, A_T0, A_T0);
      7'd52: u = lrk_uop(OP_ADD, A_QZ, A_PZ, A_T0);
      [7'd53:7'd61]: begin
        rel = pc - PcD3;
        u = lrk_deriv(rel[3:0], A_QX, A_QY, A_QZ);
      end
      7'd62: u = lrk_uop(OP_ADD, A_BX, A_KX, A_KX);
      7'd63: u = lrk_uop(OP_ADD, A_BY, A_KY, A_KY);
      7'd64: u = lrk_uop(OP_ADD, A_BZ, A_KZ, A_KZ);
      7'd65: u = lrk_uop(OP_MUL, A_T0, A_H, A_KX);
      7'd66: u = lrk_uop(OP_ADD, A_QX, A_PX, A_T0);
      7'd67: u = lrk_uop(OP_MUL, A_T0, A_H, A_KY);
      7'd68: u = lrk_uop(OP_ADD, A_QY, A_PY, A_T0);
      7'd69: u = lrk_uop(OP_MUL, A_T0, A_H, A_KZ);
      7'd70: u = lrk_uop(OP_ADD, A_QZ, A_PZ, A_T0);
      [7'd71:7'd79]: begin
        rel = pc - PcD4;
        u = lrk_deriv(rel[3:0], A_QX, A_QY, A_QZ);
      end
      7'd80: u = lrk_uop(OP_ADD, A_BX, A_BX, A_KX);
      7'd81: u = lrk_uop(OP_ADD, A_T0, A_SX, A_BX);
      7'd82: u = lrk_uop(OP_MUL, A_T0, A_H, A_T0);
      7'd83: u = lrk_uop(OP_DIV6, A_T0, A_T0, A_T0);
      7'd84: u = lrk_uop(OP_ADD, A_T0, A_PX, A_T0);
      7'd85: u = lrk_uop(OP_CLAMP, A_PX, A_T0, A_T0);
      7'd86: u = lrk_uop(OP_ADD, A_BY, A_BY, A_KY);
      7'd87: u = lrk_uop(OP_ADD, A_T0, A_SY, A_BY);
      7'd88: u = lrk_uop(OP_MUL, A_T0, A_H, A_T0);
      7'd89: u = lrk_uop(OP_DIV6, A_T0, A_T0, A_T0);
      7'd90: u = lrk_uop(OP_ADD, A_T0, A_PY, A_T0);
      7'd91: u = lrk_uop(OP_CLAMP, A_PY, A_T0, A_T0);
      7'd92: u = lrk_uop(OP_ADD, A_BZ, A_BZ, A_KZ);
      7'd93: u = lrk_uop(OP_ADD, A_T0, A_SZ, A_BZ);
      7'd94: u = lrk_uop(OP_MUL, A_T0, A_H, A_T0);
      7'd95: u = lrk_uop(OP_DIV6, A_T0, A_T0, A_T0);
      7'd96: u = lrk_uop(OP_ADD, A_T0, A_PZ, A_T0);
      7'd97: u = lrk_uop(OP_CLAMP, A_PZ, A_T0, A_T0);
      default: u = lrk_uop(OP_END, A_T0, A_T0, A_T0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* design/lrk_if.sv */
// Handshake channel interfaces of the Lorenz RK4 integrator: request input,
// result output and configuration write. No dependencies.
`default_nettype none

interface lrk_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lrk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input saturated, output ready);
endinterface

interface lrk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/lrk_ctrl.sv */
// Microprogram sequencer of the Lorenz RK4 integrator.
// Depends on lrk_pkg for the microcode table and command types.
`default_nettype none

module lrk_ctrl import lrk_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_restart_i,
  output logic          in_ready_o,
  output lrk_cmd_t      cmd_o,
  input  wire lrk_sts_t sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [6:0] pc_q, pc_d;
  logic       init_q, init_d;
  logic       first_q, first_d;
  uop_t       uop;

  assign uop = lrk_ucode(pc_q);

  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    init_d          = init_q;
    first_d         = first_q;
    in_ready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.first     = 1'b0;
    cmd_o.clear_sat = 1'b0;
    cmd_o.push      = 1'b0;
    cmd_o.op        = uop.op;
    cmd_o.dst       = uop.dst;
    cmd_o.src_a     = uop.src_a;
    cmd_o.src_b     = uop.src_b;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.clear_sat = 1'b1;
          pc_d            = in_restart_i ? PcRestart : PcStep;
          state_d         = S_FETCH;
        end
      end
      S_FETCH: begin
        if (uop.op == OP_END) begin
          state_d = init_q ? S_IDLE : S_PUSH;
          init_d  = 1'b0;
        end else begin
          cmd_o.load = 1'b1;
          first_d    = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec  = 1'b1;
        cmd_o.first = first_q;
        first_d     = 1'b0;
        if (sts_i.done) begin
          pc_d    = pc_q + 7'd1;
          state_d = S_FETCH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FETCH;
      pc_q    <= PcInit;
      init_q  <= 1'b1;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      init_q  <= init_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

/* design/lrk_dp.sv */
// Datapath of the Lorenz RK4 integrator: configuration registers, register
// file, saturating ALU, shared multiplier, divide-by-six unit, result register.
// Depends on lrk_pkg for types, addresses and register indexes.
`default_nettype none

module lrk_dp import lrk_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int STATE_WIDTH = StateWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lrk_cmd_t    cmd_i,
  output lrk_sts_t         sts_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o,
  output logic [31:0]      out_z_o,
  output logic             out_sat_o
);

  localparam int AlignL = (FRAC_BITS >= RegFrac) ? FRAC_BITS - RegFrac : 0;
  localparam int AlignR = (FRAC_BITS < RegFrac) ? RegFrac - FRAC_BITS : 0;
  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] StMax = SMax >> (64 - STATE_WIDTH);
  localparam logic [63:0] StMin = ~StMax;
  localparam logic [4:0] MulSteps = 5'd4;
  localparam logic [4:0] DivSteps = 5'd16;
  localparam int RfDepth = 32;

  // Configuration registers.
  logic [23:0] step_q;
  logic [30:0] sigma_q, rho_q, beta_q;
  logic [31:0] stx_q, sty_q, stz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepRst;
      sigma_q <= SigmaRst;
      rho_q   <= RhoRst;
      beta_q  <= BetaRst;
      stx_q   <= StartRst;
      sty_q   <= StartRst;
      stz_q   <= StartRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStep:   step_q  <= cfg_data_i[23:0];
        CfgSigma:  sigma_q <= cfg_data_i[30:0];
        CfgRho:    rho_q   <= cfg_data_i[30:0];
        CfgBeta:   beta_q  <= cfg_data_i[30:0];
        CfgStartX: stx_q   <= cfg_data_i;
        CfgStartY: sty_q   <= cfg_data_i;
        CfgStartZ: stz_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [63:0] align(logic [63:0] v);
    return 64'(($signed(v) <<< AlignL) >>> AlignR);
  endfunction

  function automatic logic [63:0] cfg_word(logic [4:0] adr);
    logic [63:0] v;
    unique case (adr)
      A_ONE:   v = {32'd0, StartRst};
      A_H:     v = {40'd0, step_q};
      A_SG:    v = {33'd0, sigma_q};
      A_RG:    v = {33'd0, rho_q};
      A_BG:    v = {33'd0, beta_q};
      A_STX:   v = {{32{stx_q[31]}}, stx_q};
      A_STY:   v = {{32{sty_q[31]}}, sty_q};
      A_STZ:   v = {{32{stz_q[31]}}, stz_q};
      default: v = 64'd0;
    endcase
    return align(v);
  endfunction

  // Register file with registered two-port read.
  logic [63:0] rf_q [RfDepth];
  logic [63:0] rd_a_q, rd_b_q, cw_a_q, cw_b_q;
  logic        sel_a_q, sel_b_q;
  logic [63:0] op_a, op_b;
  logic        wr_en;
  logic [63:0] res;
  logic        res_sat;
  logic        op_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_a_q  <= rf_q[cmd_i.src_a];
      rd_b_q  <= rf_q[cmd_i.src_b];
      cw_a_q  <= cfg_word(cmd_i.src_a);
      cw_b_q  <= cfg_word(cmd_i.src_b);
      sel_a_q <= (cmd_i.src_a[4:3] == 2'b11);
      sel_b_q <= (cmd_i.src_b[4:3] == 2'b11);
    end
    if (wr_en) begin
      rf_q[cmd_i.dst] <= res;
    end
  end

  assign op_a = sel_a_q ? cw_a_q : rd_a_q;
  assign op_b = sel_b_q ? cw_b_q : rd_b_q;

  // Multiplier and divider state.
  logic [63:0]  ma_q, mb_q, dq_q;
  logic [127:0] acc_q;
  logic [2:0]   rem_q;
  logic         neg_q;
  logic [4:0]   cnt_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  dq_n;
  logic [2:0]   rem_n;
  logic [3:0]   r4;
  logic [63:0]  mag_a, mag_b;

  assign mag_a = op_a[63] ? (~op_a + 64'd1) : op_a;
  assign mag_b = op_b[63] ? (~op_b + 64'd1) : op_b;
  assign pa    = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb    = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp    = pa * pb;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Four quotient bits of the division by six per cycle.
  always_comb begin
    dq_n  = dq_q;
    rem_n = rem_q;
    r4    = 4'd0;
    for (int i = 0; i < 4; i++) begin
      r4   = {rem_n, dq_n[63]};
      dq_n = {dq_n[62:0], 1'b0};
      if (r4 >= 4'd6) begin
        rem_n   = 3'(r4 - 4'd6);
        dq_n[0] = 1'b1;
      end else begin
        rem_n = r4[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (cmd_i.exec) begin
      if (cmd_i.first) begin
        cnt_q <= 5'd0;
      end else if (cnt_q != DivSteps) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && cmd_i.first) begin
      ma_q  <= mag_a;
      mb_q  <= mag_b;
      dq_q  <= mag_a;
      rem_q <= 3'd0;
      acc_q <= 128'd0;
      neg_q <= (cmd_i.op == OP_MUL) ? (op_a[63] ^ op_b[63]) : op_a[63];
    end else if (cmd_i.exec) begin
      if (cmd_i.op == OP_MUL && cnt_q < MulSteps) begin
        acc_q <= acc_q + pp_sh;
      end
      if (cmd_i.op == OP_DIV6 && cnt_q < DivSteps) begin
        dq_q  <= dq_n;
        rem_q <= rem_n;
      end
    end
  end

  // Result of the operation in execution.
  logic [63:0] sum, dif, mmag;
  logic        add_ov, sub_ov, mul_ov;

  assign sum    = op_a + op_b;
  assign dif    = op_a - op_b;
  assign add_ov = (op_a[63] == op_b[63]) && (sum[63] != op_a[63]);
  assign sub_ov = (op_a[63] != op_b[63]) && (dif[63] != op_a[63]);
  assign mmag   = acc_q[FRAC_BITS +: 64];
  assign mul_ov = (|acc_q[127:64+FRAC_BITS]) ||
                  (neg_q ? (mmag > SMin) : mmag[63]);

  always_comb begin
    res     = op_a;
    res_sat = 1'b0;
    op_done = 1'b0;
    case (cmd_i.op)
      OP_MOV: begin
        op_done = 1'b1;
      end
      OP_ADD: begin
        op_done = 1'b1;
        res_sat = add_ov;
        res     = add_ov ? (op_a[63] ? SMin : SMax) : sum;
      end
      OP_SUB: begin
        op_done = 1'b1;
        res_sat = sub_ov;
        res     = sub_ov ? (op_a[63] ? SMin : SMax) : dif;
      end
      OP_ASR: begin
        op_done = 1'b1;
        res     = {op_a[63], op_a[63:1]};
      end
      OP_CLAMP: begin
        op_done = 1'b1;
        if ($signed(op_a) > $signed(StMax)) begin
          res_sat = 1'b1;
          res     = StMax;
        end else if ($signed(op_a) < $signed(StMin)) begin
          res_sat = 1'b1;
          res     = StMin;
        end
      end
      OP_MUL: begin
        op_done = !cmd_i.first && (cnt_q == MulSteps);
        res_sat = mul_ov;
        if (mul_ov) begin
          res = neg_q ? SMin : SMax;
        end else begin
          res = neg_q ? (~mmag + 64'd1) : mmag;
        end
      end
      OP_DIV6: begin
        op_done = !cmd_i.first && (cnt_q == DivSteps);
        res     = neg_q ? (~dq_q + 64'd1) : dq_q;
      end
      default: ;
    endcase
  end

  assign wr_en = cmd_i.exec && op_done;

  // Saturation flag, position shadow and result register.
  logic        sat_q;
  logic [31:0] pos_lo_q [3];
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.clear_sat) begin
      sat_q <= 1'b0;
    end else if (wr_en && res_sat) begin
      sat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cmd_i.dst <= A_PZ) begin
      pos_lo_q[cmd_i.dst[1:0]] <= res[31:0];
    end
    if (cmd_i.push) begin
      out_x_o   <= pos_lo_q[0];
      out_y_o   <= pos_lo_q[1];
      out_z_o   <= pos_lo_q[2];
      out_sat_o <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sts_o       = '{done: op_done, out_free: !out_valid_q || out_ready_i};

endmodule

`default_nettype wire

/* design/lorenz_rk4_step_core.sv */
// Top level of the Lorenz RK4 integrator: joins the sequencer and the datapath.
// Depends on lrk_pkg, lrk_if, lrk_ctrl and lrk_dp.
`default_nettype none

// The block holds a Lorenz point (x, y, z) in signed fixed point with
// FRAC_BITS fraction bits and clamps it to STATE_WIDTH bits. Each request on
// in_i either reloads the point from the start registers (restart = 1) or
// advances it by one classic fourth-order Runge-Kutta step, and produces one
// result on out_o carrying the low 32 bits of each coordinate and a flag that
// is set when any intermediate or the new point saturated. All work is done
// by a microprogram on a single 64-bit register file and one shared 32x32
// multiplier, so a request is taken only when the previous one has finished.
// Each of the 32 multiplications of a step runs through the four partial
// products of the shared multiplier, its three divisions by six make four
// quotient bits a cycle, and its other operations are adds, subtracts,
// moves, shifts and clamps. After reset the block loads the reset point
// before it takes its first request.
// A finished result waits in an output register, and the block goes on with
// the next request while it waits; configuration writes are always accepted
// and should be made only while no request is in progress.

module lorenz_rk4_step_core import lrk_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int STATE_WIDTH = StateWidthDef
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lrk_in_if.sink    in_i,
  lrk_out_if.source out_o,
  lrk_cfg_if.sink   cfg_i
);

  lrk_cmd_t    cmd;
  lrk_sts_t    sts;
  logic [31:0] out_x, out_y, out_z;

  lrk_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  lrk_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .out_sat_o   (out_o.saturated)
  );

  // The configuration channel never stalls.
  assign cfg_i.ready = 1'b1;
  assign out_o.out_x = $signed(out_x);
  assign out_o.out_y = $signed(out_y);
  assign out_o.out_z = $signed(out_z);

endmodule

`default_nettype wire

/* design/lrk_checker.sv */
// Port-level checks of the Lorenz RK4 integrator and their bind to the top.
// Depends on lorenz_rk4_step_core and the lrk_if interfaces.
`default_nettype none

module lrk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_x_i,
  input wire logic        out_sat_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_sat_i))
    else $error("stalled result changed");

  // One request at a time: ready drops once a request is taken.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // A new result cannot appear in the cycle after a request is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind lorenz_rk4_step_core lrk_checker u_lrk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_sat_i   (out_o.saturated)
);

`default_nettype wire
